FILE: src/dpsq_pkg.sv
// shared types and constants for the deferred packet sorted queue
`default_nettype none

package dpsq_pkg;

   // fixed field widths
   localparam int ACTION_WIDTH = 3;
   localparam int SEQ_WIDTH    = 32;
   localparam int TIME_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int SPOS_WIDTH   = 4;
   localparam int COUNT_WIDTH  = 5;
   localparam int CAP_WIDTH    = 5;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;
   localparam logic [SEQ_WIDTH-1:0] SEQ_MAX   = 32'hFFFF_FFFF;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_MISSING = 2'd2;

   // request actions
   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_ADD      = 3'd0,
      ACT_REMOVE   = 3'd1,
      ACT_LOOKUP   = 3'd2,
      ACT_SMALLEST = 3'd3,
      ACT_CLEAR    = 3'd4
   } action_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_EXEC,
      S_SCAN
   } state_type;

   // per-cell update command
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_LEFT,
      CELL_RIGHT
   } cell_op_type;

   // registered compare results of one cell
   typedef struct packed {
      logic time_gt;
      logic seq_eq;
   } cell_flags_type;

endpackage

`default_nettype wire

FILE: src/dpsq_cell.sv
// one queue cell: holds an entry, compares it with the key, shifts with its neighbors
`default_nettype none

module dpsq_cell
   import dpsq_pkg::*;
#(
   parameter int HANDLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire cell_op_type            op,
   input  wire logic [SEQ_WIDTH-1:0]   key_seq,
   input  wire logic [TIME_WIDTH-1:0]  key_arr,
   input  wire logic [HANDLE_BITS-1:0] key_hnd,
   input  wire logic [SEQ_WIDTH-1:0]   left_seq,
   input  wire logic [TIME_WIDTH-1:0]  left_arr,
   input  wire logic [HANDLE_BITS-1:0] left_hnd,
   input  wire logic [SEQ_WIDTH-1:0]   right_seq,
   input  wire logic [TIME_WIDTH-1:0]  right_arr,
   input  wire logic [HANDLE_BITS-1:0] right_hnd,
   output logic [SEQ_WIDTH-1:0]        cell_seq,
   output logic [TIME_WIDTH-1:0]       cell_arr,
   output logic [HANDLE_BITS-1:0]      cell_hnd,
   output cell_flags_type              flags
);

   logic [SEQ_WIDTH-1:0]   seq_ff, seq_in;
   logic [TIME_WIDTH-1:0]  arr_ff, arr_in;
   logic [HANDLE_BITS-1:0] hnd_ff, hnd_in;
   cell_flags_type         flags_ff, flags_in;

   // entry update from the key or a neighbor
   always_comb begin
      seq_in = seq_ff;
      arr_in = arr_ff;
      hnd_in = hnd_ff;
      case (op)
         CELL_LOAD: begin
            seq_in = key_seq;
            arr_in = key_arr;
            hnd_in = key_hnd;
         end
         CELL_LEFT: begin
            seq_in = left_seq;
            arr_in = left_arr;
            hnd_in = left_hnd;
         end
         CELL_RIGHT: begin
            seq_in = right_seq;
            arr_in = right_arr;
            hnd_in = right_hnd;
         end
         default: begin
            seq_in = seq_ff;
            arr_in = arr_ff;
            hnd_in = hnd_ff;
         end
      endcase
   end

   // compare against the key
   always_comb begin
      flags_in.time_gt = (arr_ff > key_arr);
      flags_in.seq_eq  = (seq_ff == key_seq);
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      arr_ff   <= arr_in;
      hnd_ff   <= hnd_in;
      flags_ff <= flags_in;
   end

   assign cell_seq = seq_ff;
   assign cell_arr = arr_ff;
   assign cell_hnd = hnd_ff;
   assign flags    = flags_ff;

endmodule

`default_nettype wire

FILE: src/deferred_packet_sorted_queue_core.sv
// top level: sequencer, response register and the row of queue cells
// sequence: a request word is accepted in idle, the cell compares are registered in the
//   compare state, and the update state commits the action and loads the result word;
//   find-smallest then scans the sequence numbers, one cell per cycle, before its result
// a new request word is taken only after the result of the last one is loaded; the update
//   state and the end of the scan wait while an earlier result is still held unaccepted
// reset: synchronous, clears the entry count and sets capacity to 16; cell contents are kept
`default_nettype none

module deferred_packet_sorted_queue_core
   import dpsq_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // req_tdata: seq_number, arrival_time, payload_handle, zero fill
   input  wire logic [((SEQ_WIDTH+TIME_WIDTH+HANDLE_BITS+7)/8)*8-1:0] req_tdata,
   // req_tuser: action
   input  wire logic [ACTION_WIDTH-1:0] req_tuser,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // rsp_tdata: found_time, found_handle, smallest_position, entry_count, full_res, zero fill
   output logic [((TIME_WIDTH+HANDLE_BITS+SPOS_WIDTH+COUNT_WIDTH+1+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: status
   output logic [STATUS_WIDTH-1:0]      rsp_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [CAP_WIDTH-1:0]    csr_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready
);

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CW         = (CNT_BITS > CAP_WIDTH) ? CNT_BITS : CAP_WIDTH;
   localparam int RSP_FIELDS = TIME_WIDTH + HANDLE_BITS + SPOS_WIDTH + COUNT_WIDTH + 1;
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

   // full when count reaches capacity, capacity above depth acts as depth
   function automatic logic is_full(input logic [CNT_BITS-1:0]  cnt,
                                    input logic [CAP_WIDTH-1:0] cap);
      return (CW'(cnt) >= CW'(cap)) || (cnt == DEPTH_CNT);
   endfunction

   state_type                state_ff, state_in;
   logic [CAP_WIDTH-1:0]     capacity_ff, capacity_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   action_type               act_ff, act_in;
   logic [SEQ_WIDTH-1:0]     kseq_ff, kseq_in;
   logic [TIME_WIDTH-1:0]    karr_ff, karr_in;
   logic [HANDLE_BITS-1:0]   khnd_ff, khnd_in;

   logic [CNT_BITS-1:0]      scan_idx_ff, scan_idx_in;
   logic [SEQ_WIDTH-1:0]     best_seq_ff, best_seq_in;
   logic [IDX_BITS-1:0]      best_pos_ff, best_pos_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_WIDTH-1:0]  rsp_status_ff, rsp_status_in;
   logic [TIME_WIDTH-1:0]    rsp_arr_ff, rsp_arr_in;
   logic [HANDLE_BITS-1:0]   rsp_hnd_ff, rsp_hnd_in;
   logic [SPOS_WIDTH-1:0]    rsp_spos_ff, rsp_spos_in;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic [SEQ_WIDTH-1:0]     cell_seq  [DEPTH];
   logic [TIME_WIDTH-1:0]    cell_arr  [DEPTH];
   logic [HANDLE_BITS-1:0]   cell_hnd  [DEPTH];
   cell_flags_type           cell_flg  [DEPTH];
   cell_op_type              cell_op   [DEPTH];
   logic [SEQ_WIDTH-1:0]     left_seq  [DEPTH];
   logic [TIME_WIDTH-1:0]    left_arr  [DEPTH];
   logic [HANDLE_BITS-1:0]   left_hnd  [DEPTH];
   logic [SEQ_WIDTH-1:0]     right_seq [DEPTH];
   logic [TIME_WIDTH-1:0]    right_arr [DEPTH];
   logic [HANDLE_BITS-1:0]   right_hnd [DEPTH];

   logic [DEPTH-1:0]         load_v, left_v, first_eq_v, shift_v;
   logic                     any_gt, any_eq, occ, gt_b, eq_b;
   logic [TIME_WIDTH-1:0]    found_arr;
   logic [HANDLE_BITS-1:0]   found_hnd;
   logic                     full_now, drop;

   logic                     out_free, commit, scan_start, scan_step, scan_finish, rsp_load;
   logic                     scan_done;
   logic [SEQ_WIDTH-1:0]     scan_seq;
   logic [CNT_BITS+COUNT_WIDTH-1:0] count_wide;
   logic [IDX_BITS+SPOS_WIDTH-1:0]  spos_wide;

   // neighbor wiring along the row
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            left_seq[i] = kseq_ff;
            left_arr[i] = karr_ff;
            left_hnd[i] = khnd_ff;
         end else begin
            left_seq[i] = cell_seq[i-1];
            left_arr[i] = cell_arr[i-1];
            left_hnd[i] = cell_hnd[i-1];
         end
         if (i == DEPTH - 1) begin
            right_seq[i] = cell_seq[i];
            right_arr[i] = cell_arr[i];
            right_hnd[i] = cell_hnd[i];
         end else begin
            right_seq[i] = cell_seq[i+1];
            right_arr[i] = cell_arr[i+1];
            right_hnd[i] = cell_hnd[i+1];
         end
      end
   end

   // the cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      dpsq_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op[g]),
         .key_seq   (kseq_ff),
         .key_arr   (karr_ff),
         .key_hnd   (khnd_ff),
         .left_seq  (left_seq[g]),
         .left_arr  (left_arr[g]),
         .left_hnd  (left_hnd[g]),
         .right_seq (right_seq[g]),
         .right_arr (right_arr[g]),
         .right_hnd (right_hnd[g]),
         .cell_seq  (cell_seq[g]),
         .cell_arr  (cell_arr[g]),
         .cell_hnd  (cell_hnd[g]),
         .flags     (cell_flg[g])
      );
   end

   // insert point, first match and lookup select from the cell flags
   always_comb begin
      any_gt    = 1'b0;
      any_eq    = 1'b0;
      occ       = 1'b0;
      gt_b      = 1'b0;
      eq_b      = 1'b0;
      found_arr = '0;
      found_hnd = '0;
      for (int i = 0; i < DEPTH; i++) begin
         occ           = (CNT_BITS'(i) < count_ff);
         gt_b          = !occ || cell_flg[i].time_gt;
         eq_b          = occ && cell_flg[i].seq_eq;
         load_v[i]     = gt_b && !any_gt;
         left_v[i]     = any_gt;
         first_eq_v[i] = eq_b && !any_eq;
         shift_v[i]    = any_eq || first_eq_v[i];
         any_gt        = any_gt || gt_b;
         any_eq        = any_eq || eq_b;
         if (first_eq_v[i]) begin
            found_arr = found_arr | cell_arr[i];
            found_hnd = found_hnd | cell_hnd[i];
         end
      end
   end

   assign full_now  = is_full(count_ff, capacity_ff);
   assign drop      = full_now;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign scan_done = !(scan_idx_ff < count_ff);
   assign scan_seq  = cell_seq[scan_idx_ff[IDX_BITS-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (act_ff == ACT_SMALLEST) state_in = S_SCAN;
            else if (out_free)          state_in = S_IDLE;
         end
         S_SCAN: begin
            if (scan_done && out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      commit      = 1'b0;
      scan_start  = 1'b0;
      scan_step   = 1'b0;
      scan_finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_EXEC: begin
            scan_start = (act_ff == ACT_SMALLEST);
            commit     = (act_ff != ACT_SMALLEST) && out_free;
         end
         S_SCAN: begin
            scan_step   = !scan_done;
            scan_finish = scan_done && out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_load = commit || scan_finish;

   // cell commands and count update
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
      end
      if (commit) begin
         case (act_ff)
            ACT_ADD: begin
               if (!drop) begin
                  count_in = count_ff + 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (load_v[i])      cell_op[i] = CELL_LOAD;
                     else if (left_v[i]) cell_op[i] = CELL_LEFT;
                  end
               end
            end
            ACT_REMOVE: begin
               if (any_eq) begin
                  count_in = count_ff - 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (shift_v[i]) cell_op[i] = CELL_RIGHT;
                  end
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // key capture on an accepted word
   always_comb begin
      act_in  = act_ff;
      kseq_in = kseq_ff;
      karr_in = karr_ff;
      khnd_in = khnd_ff;
      if (req_tvalid && req_tready) begin
         act_in  = action_type'(req_tuser);
         kseq_in = req_tdata[SEQ_WIDTH-1:0];
         karr_in = req_tdata[SEQ_WIDTH+TIME_WIDTH-1:SEQ_WIDTH];
         khnd_in = req_tdata[SEQ_WIDTH+TIME_WIDTH+HANDLE_BITS-1:SEQ_WIDTH+TIME_WIDTH];
      end
   end

   // smallest sequence scan, one cell per cycle, earliest position wins ties
   always_comb begin
      scan_idx_in = scan_idx_ff;
      best_seq_in = best_seq_ff;
      best_pos_in = best_pos_ff;
      if (scan_start) begin
         scan_idx_in = '0;
         best_seq_in = SEQ_MAX;
         best_pos_in = '0;
      end else if (scan_step) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (scan_seq < best_seq_ff) begin
            best_seq_in = scan_seq;
            best_pos_in = scan_idx_ff[IDX_BITS-1:0];
         end
      end
   end

   // response register
   always_comb begin
      count_wide    = {{COUNT_WIDTH{1'b0}}, count_in};
      spos_wide     = {{SPOS_WIDTH{1'b0}}, best_pos_ff};
      rsp_status_in = rsp_status_ff;
      rsp_arr_in    = rsp_arr_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_spos_in   = rsp_spos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      if (rsp_load) begin
         rsp_status_in = ST_DONE;
         rsp_arr_in    = '0;
         rsp_hnd_in    = '0;
         rsp_spos_in   = '0;
         rsp_count_in  = count_wide[COUNT_WIDTH-1:0];
         rsp_full_in   = is_full(count_in, capacity_ff);
         if (scan_finish) begin
            rsp_spos_in = spos_wide[SPOS_WIDTH-1:0];
         end else begin
            case (act_ff)
               ACT_ADD: begin
                  if (drop) rsp_status_in = ST_FULL;
               end
               ACT_REMOVE: begin
                  if (!any_eq) rsp_status_in = ST_MISSING;
               end
               ACT_LOOKUP: begin
                  if (any_eq) begin
                     rsp_arr_in = found_arr;
                     rsp_hnd_in = found_hnd;
                  end else begin
                     rsp_status_in = ST_MISSING;
                  end
               end
               default: begin
                  rsp_status_in = ST_DONE;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (rsp_load)        rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
      else                 rsp_tvalid_in = rsp_tvalid_ff;
   end

   // capacity register, always writable
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         capacity_ff   <= CAP_RESET;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      kseq_ff       <= kseq_in;
      karr_ff       <= karr_in;
      khnd_ff       <= khnd_in;
      scan_idx_ff   <= scan_idx_in;
      best_seq_ff   <= best_seq_in;
      best_pos_ff   <= best_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_arr_ff    <= rsp_arr_in;
      rsp_hnd_ff    <= rsp_hnd_in;
      rsp_spos_ff   <= rsp_spos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // result word packing
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_FIELDS-1:0] = {rsp_full_ff, rsp_count_ff, rsp_spos_ff,
                                   rsp_hnd_ff, rsp_arr_ff};
   end
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above depth");

   a_count_only_on_update : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(count_ff))
      else $error("entry count changed outside the update cycle");

   a_single_insert : assert property (@(posedge clock) disable iff (reset)
      (commit && act_ff == ACT_ADD && !drop) |-> $onehot(load_v))
      else $error("insert does not load exactly one cell");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_eq_v))
      else $error("more than one first match");

   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      (commit && act_ff == ACT_ADD && !drop) |-> (count_ff < DEPTH_CNT))
      else $error("insert into a full row");

endmodule

`default_nettype wire
